>>> rtl/vtgd_pkg.sv
`timescale 1ns / 1ps
package vtgd_pkg;

  localparam int MAX_GEOMETRY_WORDS = 65536;
  localparam int FIFO_DEPTH         = 4;
  localparam int FIFO_PTR_W         = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W         = $clog2(FIFO_DEPTH + 1);

  // Command ids in the low three bits of a header word
  localparam logic [2:0] CMD_MOVE_TO = 3'd1;
  localparam logic [2:0] CMD_LINE_TO = 3'd2;

  // Feature types
  localparam logic [1:0] FT_POINT = 2'd1;
  localparam logic [1:0] FT_LINE  = 2'd2;

  // Geometry kinds reported in the summary
  localparam logic [1:0] GK_NONE   = 2'd0;
  localparam logic [1:0] GK_POINT  = 2'd1;
  localparam logic [1:0] GK_SINGLE = 2'd2;
  localparam logic [1:0] GK_MULTI  = 2'd3;

  typedef enum logic [1:0] {
    RK_VERTEX  = 2'd0,
    RK_POINT   = 2'd1,
    RK_SUMMARY = 2'd2
  } res_kind_e;

  typedef enum logic [2:0] {
    PH_IGNORE   = 3'd0,
    PH_POINT    = 3'd1,
    PH_MOVE_HDR = 3'd2,
    PH_MOVE_X   = 3'd3,
    PH_MOVE_Y   = 3'd4,
    PH_LINE_HDR = 3'd5,
    PH_VERT_X   = 3'd6,
    PH_VERT_Y   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [31:0] word;
    logic        starts_geometry;
    logic [16:0] geometry_length;
    logic [1:0]  feature_type;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [13:0]        line_number;
    logic               ends_line;
    logic [1:0]         geometry_kind;
    logic [13:0]        lines_found;
    logic               last_of_run;
  } out_word_t;

  // Up to two results produced by one decoded word
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  r1;
    out_word_t  r0;
  } push_t;

  function automatic logic [31:0] unzig(input logic [31:0] w);
    unzig = {1'b0, w[31:1]} ^ {32{w[0]}};
  endfunction

endpackage

>>> rtl/vtgd_decode.sv
`timescale 1ns / 1ps
module vtgd_decode import vtgd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_word_t item_i,
  output push_t    push_o
);

  localparam logic [16:0] MaxWords = 17'(MAX_GEOMETRY_WORDS);

  logic [16:0] exp_q, exp_d;
  logic [16:0] seen_q, seen_d;
  logic [1:0]  kind_q, kind_d;
  phase_e      phase_q, phase_d, ph_cur;
  logic [15:0] vleft_q, vleft_d;
  logic [31:0] accx_q, accx_d;
  logic [31:0] accy_q, accy_d;
  logic [31:0] pendx_q, pendx_d;
  logic        pok_q, pok_d;
  logic [13:0] ltot_q, ltot_d;

  logic [2:0]  id;
  logic [28:0] cnt;
  logic [31:0] zz;
  logic [16:0] len_sat;
  logic [30:0] cnt2;
  logic        run;
  logic        fin;
  logic        vert_v;
  out_word_t   vert_r;
  out_word_t   pt_r;
  out_word_t   sum_r;
  logic [1:0]  gk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      seen_q  <= '0;
      kind_q  <= '0;
      phase_q <= PH_IGNORE;
      vleft_q <= '0;
      accx_q  <= '0;
      accy_q  <= '0;
      pendx_q <= '0;
      pok_q   <= 1'b0;
      ltot_q  <= '0;
    end else begin
      exp_q   <= exp_d;
      seen_q  <= seen_d;
      kind_q  <= kind_d;
      phase_q <= phase_d;
      vleft_q <= vleft_d;
      accx_q  <= accx_d;
      accy_q  <= accy_d;
      pendx_q <= pendx_d;
      pok_q   <= pok_d;
      ltot_q  <= ltot_d;
    end
  end

  always_comb begin
    exp_d   = exp_q;
    seen_d  = seen_q;
    kind_d  = kind_q;
    phase_d = phase_q;
    vleft_d = vleft_q;
    accx_d  = accx_q;
    accy_d  = accy_q;
    pendx_d = pendx_q;
    pok_d   = pok_q;
    ltot_d  = ltot_q;
    push_o  = '0;
    vert_v  = 1'b0;
    vert_r  = '0;
    pt_r    = '0;
    sum_r   = '0;
    gk      = GK_NONE;
    run     = 1'b0;
    fin     = 1'b0;
    ph_cur  = PH_IGNORE;

    id      = item_i.word[2:0];
    cnt     = item_i.word[31:3];
    zz      = unzig(item_i.word);
    len_sat = (item_i.geometry_length > MaxWords) ? MaxWords : item_i.geometry_length;
    cnt2    = {1'b0, cnt, 1'b0};

    if (fire_i) begin
      if (item_i.starts_geometry) begin
        if (item_i.geometry_length == 17'd0) begin
          exp_d   = '0;
          seen_d  = '0;
          phase_d = PH_IGNORE;
        end else begin
          exp_d   = len_sat;
          seen_d  = '0;
          kind_d  = item_i.feature_type;
          accx_d  = '0;
          accy_d  = '0;
          pendx_d = '0;
          pok_d   = 1'b0;
          ltot_d  = '0;
          vleft_d = '0;
          if (item_i.feature_type == FT_POINT) begin
            phase_d = (id == CMD_MOVE_TO && cnt != 29'd0 &&
                       cnt2 + 31'd1 <= 31'(len_sat)) ? PH_POINT : PH_IGNORE;
            seen_d  = 17'd1;
            fin     = 1'b1;
          end else begin
            phase_d = (item_i.feature_type == FT_LINE) ? PH_MOVE_HDR : PH_IGNORE;
            run     = 1'b1;
          end
        end
      end else if (seen_q < exp_q) begin
        run = 1'b1;
      end

      if (run) begin
        ph_cur = phase_d;
        case (ph_cur)
          PH_POINT: begin
            if (seen_d[0]) begin
              if ({1'b0, seen_d} + 18'd1 < {1'b0, exp_d}) pendx_d = zz;
            end else if (seen_d >= 17'd2) begin
              accx_d = pendx_d;
              accy_d = zz;
              pok_d  = 1'b1;
            end
          end
          PH_MOVE_HDR: begin
            phase_d = ({1'b0, seen_d} + 18'd6 <= {1'b0, exp_d} &&
                       id == CMD_MOVE_TO && cnt == 29'd1) ? PH_MOVE_X : PH_IGNORE;
          end
          PH_MOVE_X: begin
            pendx_d = zz;
            phase_d = PH_MOVE_Y;
          end
          PH_MOVE_Y: begin
            accx_d  = accx_d + pendx_d;
            accy_d  = accy_d + zz;
            phase_d = PH_LINE_HDR;
          end
          PH_LINE_HDR: begin
            if (id == CMD_LINE_TO && cnt != 29'd0 &&
                cnt2 + 31'(seen_d) + 31'd1 <= 31'(exp_d)) begin
              vert_v             = 1'b1;
              vert_r.result_kind = RK_VERTEX;
              vert_r.coord_x     = accx_d;
              vert_r.coord_y     = accy_d;
              vert_r.line_number = ltot_d;
              vleft_d            = cnt[15:0];
              phase_d            = PH_VERT_X;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_VERT_X: begin
            pendx_d = zz;
            phase_d = PH_VERT_Y;
          end
          PH_VERT_Y: begin
            accx_d  = accx_d + pendx_d;
            accy_d  = accy_d + zz;
            if (vleft_d != 16'd0) vleft_d = vleft_d - 16'd1;
            vert_v             = 1'b1;
            vert_r.result_kind = RK_VERTEX;
            vert_r.coord_x     = accx_d;
            vert_r.coord_y     = accy_d;
            vert_r.line_number = ltot_d;
            vert_r.ends_line   = (vleft_d == 16'd0);
            if (vleft_d == 16'd0) begin
              ltot_d  = ltot_d + 14'd1;
              phase_d = PH_MOVE_HDR;
            end else begin
              phase_d = PH_VERT_X;
            end
          end
          default: begin
          end
        endcase
        seen_d = seen_d + 17'd1;
        fin    = 1'b1;
      end

      if (fin && seen_d == exp_d) begin
        // Final word: optional point or vertex, then the summary
        if (kind_d == FT_POINT) begin
          if (pok_d) gk = GK_POINT;
        end else if (kind_d == FT_LINE) begin
          if (ltot_d == 14'd1) gk = GK_SINGLE;
          else if (ltot_d > 14'd1) gk = GK_MULTI;
        end
        sum_r.result_kind   = RK_SUMMARY;
        sum_r.geometry_kind = gk;
        sum_r.lines_found   = (kind_d == FT_LINE) ? ltot_d : 14'd0;
        sum_r.last_of_run   = 1'b1;
        pt_r.result_kind    = RK_POINT;
        pt_r.coord_x        = accx_d;
        pt_r.coord_y        = accy_d;
        phase_d             = PH_IGNORE;
        if (vert_v) begin
          push_o.r0  = vert_r;
          push_o.r1  = sum_r;
          push_o.cnt = 2'd2;
        end else if (kind_d == FT_POINT && pok_d) begin
          push_o.r0  = pt_r;
          push_o.r1  = sum_r;
          push_o.cnt = 2'd2;
        end else begin
          push_o.r0  = sum_r;
          push_o.cnt = 2'd1;
        end
      end else if (vert_v) begin
        push_o.r0             = vert_r;
        push_o.r0.last_of_run = 1'b1;
        push_o.cnt            = 2'd1;
      end
    end
  end

endmodule

>>> rtl/vtgd_fifo.sv
`timescale 1ns / 1ps
module vtgd_fifo import vtgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output out_word_t head_o
);

  out_word_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_q, wp_d;
  logic [FIFO_PTR_W-1:0] rp_q, rp_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wp_next;

  assign wp_next = wp_q + FIFO_PTR_W'(1);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rp_q];
  // Room for a full pair of results
  assign room_o  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wp_d    = wp_q + FIFO_PTR_W'(push_i.cnt);
    rp_d    = rp_q + FIFO_PTR_W'(pop_i);
    count_d = count_q + FIFO_CNT_W'(push_i.cnt) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wp_next] <= push_i.r1;
  end

endmodule

>>> rtl/vector_tile_geometry_decoder_core.sv
`timescale 1ns / 1ps
// A word accepted into the input register is decoded once the result queue has
// room, and its results are written into that queue, which drives out_valid_o.
// Throughput: one word per cycle while the four-entry result queue has room; a
// word with two results gives them out in turn through its single read port.
// Reset clears the decode state to idle and empties the input and result stages.
module vector_tile_geometry_decoder_core import vtgd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  in_word_t in_q;
  logic     in_vld_q, in_vld_d;
  logic     room;
  logic     fire;
  logic     accept;
  push_t    push;

  assign fire       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Hold the word until the decoder takes it
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  vtgd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .push_o (push)
  );

  vtgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && !out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (out_data_o)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vtgd_pkg::*;

  localparam logic [1:0] FT_UNKNOWN    = 2'd0;
  localparam logic [1:0] FT_POLYGON    = 2'd3;
  localparam int         RANDOM_WORDS  = 1500;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 400;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  vector_tile_geometry_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int errors         = 0;
  int words_in       = 0;
  int geo_words      = 0;
  int vertices_seen  = 0;
  int points_seen    = 0;
  int summaries_seen = 0;
  int input_held     = 0;

  // sender and receiver pacing
  int   burst_left = 0;
  int   gap_pct    = 30;
  int   stall_pct  = 20;
  int   hold_seq   = 0;
  int   hold_seen  = 0;
  int   hold_left  = 0;
  int   run_left   = 0;
  logic run_stall  = 1'b0;

  // decoder state as the block should hold it
  logic [16:0] w_total    = '0;
  logic [16:0] w_count    = '0;
  logic [1:0]  feat_held  = '0;
  phase_e      stage      = PH_IGNORE;
  logic [15:0] verts_left = '0;
  logic [31:0] pos_x      = '0;
  logic [31:0] pos_y      = '0;
  logic [31:0] hold_x     = '0;
  logic        pt_valid   = 1'b0;
  logic [13:0] lines_done = '0;

  out_word_t   decoded_q[$];
  out_word_t   head_result;
  logic [31:0] geo_buf[$];

  function automatic logic [31:0] from_zigzag(input logic [31:0] w);
    return (w >> 1) ^ (32'd0 - w[0]);
  endfunction

  function automatic logic [31:0] to_zigzag(input int v);
    return (v << 1) ^ (v >>> 31);
  endfunction

  function automatic logic [31:0] cmd_word(input logic [2:0] id, input int unsigned count);
    return {count[28:0], id};
  endfunction

  function automatic out_word_t result_of(input res_kind_e k, input logic [31:0] x,
                                          input logic [31:0] y, input logic [13:0] ln,
                                          input logic el, input logic [1:0] gk,
                                          input logic [13:0] lf);
    out_word_t r;
    r.result_kind   = k;
    r.coord_x       = x;
    r.coord_y       = y;
    r.line_number   = ln;
    r.ends_line     = el;
    r.geometry_kind = gk;
    r.lines_found   = lf;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // Advance the decoder state by one accepted word and queue what it yields.
  function automatic void decode_word(input in_word_t iw);
    out_word_t       res[2];
    int              n;
    logic [2:0]      id;
    longint unsigned cnt;
    longint unsigned len;
    longint unsigned idx;
    logic [31:0]     dv;
    logic [1:0]      gk;
    logic            header_only;
    n           = 0;
    id          = iw.word[2:0];
    cnt         = iw.word[31:3];
    dv          = from_zigzag(iw.word);
    len         = iw.geometry_length;
    header_only = 1'b0;
    if (iw.starts_geometry) begin
      if (len == 0) begin
        w_total = '0;
        w_count = '0;
        stage   = PH_IGNORE;
        return;
      end
      if (len > MAX_GEOMETRY_WORDS) len = MAX_GEOMETRY_WORDS;
      w_total    = len[16:0];
      w_count    = '0;
      feat_held  = iw.feature_type;
      pos_x      = '0;
      pos_y      = '0;
      hold_x     = '0;
      pt_valid   = 1'b0;
      lines_done = '0;
      verts_left = '0;
      if (iw.feature_type == FT_POINT) begin
        stage = (id == CMD_MOVE_TO && cnt >= 1 && cnt * 2 + 1 <= len) ? PH_POINT : PH_IGNORE;
        w_count     = 17'd1;
        header_only = 1'b1;
      end else begin
        stage = (iw.feature_type == FT_LINE) ? PH_MOVE_HDR : PH_IGNORE;
      end
    end
    if (!header_only) begin
      if (w_count >= w_total) return;
      idx = w_count;
      case (stage)
        PH_POINT: begin
          if (idx[0]) begin
            if (idx + 1 < w_total) hold_x = dv;
          end else if (idx >= 2) begin
            pos_x    = hold_x;
            pos_y    = dv;
            pt_valid = 1'b1;
          end
        end
        PH_MOVE_HDR: begin
          stage = (idx + 6 <= w_total && id == CMD_MOVE_TO && cnt == 1) ? PH_MOVE_X : PH_IGNORE;
        end
        PH_MOVE_X: begin
          hold_x = dv;
          stage  = PH_MOVE_Y;
        end
        PH_MOVE_Y: begin
          pos_x = pos_x + hold_x;
          pos_y = pos_y + dv;
          stage = PH_LINE_HDR;
        end
        PH_LINE_HDR: begin
          // the MoveTo vertex only counts once its LineTo passes
          if (id == CMD_LINE_TO && cnt >= 1 && cnt * 2 + idx + 1 <= w_total) begin
            res[n] = result_of(RK_VERTEX, pos_x, pos_y, lines_done, 1'b0, GK_NONE, '0);
            n++;
            verts_left = cnt[15:0];
            stage      = PH_VERT_X;
          end else begin
            stage = PH_IGNORE;
          end
        end
        PH_VERT_X: begin
          hold_x = dv;
          stage  = PH_VERT_Y;
        end
        PH_VERT_Y: begin
          pos_x = pos_x + hold_x;
          pos_y = pos_y + dv;
          if (verts_left != 0) verts_left--;
          res[n] = result_of(RK_VERTEX, pos_x, pos_y, lines_done, verts_left == 0,
                             GK_NONE, '0);
          n++;
          if (verts_left == 0) begin
            lines_done++;
            stage = PH_MOVE_HDR;
          end else begin
            stage = PH_VERT_X;
          end
        end
        default: ;
      endcase
      w_count++;
    end
    if (w_count == w_total) begin
      gk = GK_NONE;
      if (feat_held == FT_POINT) begin
        if (pt_valid) begin
          res[n] = result_of(RK_POINT, pos_x, pos_y, '0, 1'b0, GK_NONE, '0);
          n++;
          gk = GK_POINT;
        end
      end else if (feat_held == FT_LINE) begin
        if (lines_done == 1) gk = GK_SINGLE;
        else if (lines_done > 1) gk = GK_MULTI;
      end
      res[n] = result_of(RK_SUMMARY, '0, '0, '0, 1'b0, gk,
                         (feat_held == FT_LINE) ? lines_done : 14'd0);
      n++;
      stage = PH_IGNORE;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) decoded_q.push_back(res[k]);
  endfunction

  task automatic put_word(input logic [31:0] w, input logic st, input logic [16:0] len,
                          input logic [1:0] ft);
    in_word_t item;
    int       gap;
    item.word            = w;
    item.starts_geometry = st;
    item.geometry_length = len;
    item.feature_type    = ft;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_in++;
    decode_word(item);
  endtask

  task automatic send_geometry(input logic [16:0] len, input logic [1:0] ft);
    foreach (geo_buf[k]) begin
      if (k == 0) put_word(geo_buf[k], 1'b1, len, ft);
      else put_word(geo_buf[k], 1'b0, 17'($urandom), 2'($urandom));
      geo_words++;
    end
  endtask

  task automatic drain_results;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int any_delta();
    case ($urandom_range(0, 3))
      0, 1:    return int'($urandom_range(0, 64)) - 32;
      2:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_lines(input int lines, input int max_verts);
    int verts;
    geo_buf = {};
    repeat (lines) begin
      verts = $urandom_range(1, max_verts);
      geo_buf.push_back(cmd_word(CMD_MOVE_TO, 1));
      geo_buf.push_back(to_zigzag(any_delta()));
      geo_buf.push_back(to_zigzag(any_delta()));
      geo_buf.push_back(cmd_word(CMD_LINE_TO, verts));
      repeat (2 * verts) geo_buf.push_back(to_zigzag(any_delta()));
    end
  endfunction

  function automatic void build_points(input int count);
    geo_buf = {cmd_word(CMD_MOVE_TO, count)};
    repeat (2 * count) geo_buf.push_back(to_zigzag(any_delta()));
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b1) input_held++;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("result word with nothing pending, kind %0d", out_data_o.result_kind);
        errors++;
      end else begin
        head_result = decoded_q.pop_front();
        check_field("result_kind", head_result.result_kind, out_data_o.result_kind);
        check_field("coord_x", head_result.coord_x, out_data_o.coord_x);
        check_field("coord_y", head_result.coord_y, out_data_o.coord_y);
        check_field("line_number", head_result.line_number, out_data_o.line_number);
        check_field("ends_line", head_result.ends_line, out_data_o.ends_line);
        check_field("geometry_kind", head_result.geometry_kind, out_data_o.geometry_kind);
        check_field("lines_found", head_result.lines_found, out_data_o.lines_found);
        check_field("last_of_run", head_result.last_of_run, out_data_o.last_of_run);
        case (head_result.result_kind)
          RK_VERTEX: vertices_seen++;
          RK_POINT:  points_seen++;
          default:   summaries_seen++;
        endcase
      end
    end
  end

  // Output side: random stall runs, or one long hold when a test asks for it.
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left  = $urandom_range(1, 16);
        run_stall = $urandom_range(0, 99) < stall_pct;
      end
      run_left--;
      out_stall_i <= run_stall;
    end
  end

  task automatic test_stray_words;
    // no geometry open yet: drop the word, then an empty geometry
    put_word(32'hFFFF_FFFF, 1'b0, 17'h1_FFFF, FT_POLYGON);
    put_word(32'h0000_0000, 1'b1, 17'd0, FT_LINE);
    drain_results();
  endtask

  task automatic test_point_geometries;
    geo_buf = {cmd_word(CMD_MOVE_TO, 1), to_zigzag(32'h7FFF_FFFF), to_zigzag(32'h8000_0000)};
    send_geometry(17'd3, FT_POINT);
    geo_buf = {cmd_word(CMD_MOVE_TO, 0)};
    send_geometry(17'd1, FT_POINT);
    // the trailing odd word has no partner inside the length
    geo_buf = {cmd_word(CMD_MOVE_TO, 1), to_zigzag(-3), to_zigzag(9), 32'hFFFF_FFFF};
    send_geometry(17'd4, FT_POINT);
    drain_results();
  endtask

  task automatic test_line_geometries;
    geo_buf = {cmd_word(CMD_MOVE_TO, 1), to_zigzag(32'h7FFF_FFFF), to_zigzag(32'h7FFF_FFFF),
               cmd_word(CMD_LINE_TO, 1), to_zigzag(1), to_zigzag(1),
               cmd_word(CMD_MOVE_TO, 1), to_zigzag(-5), to_zigzag(7),
               cmd_word(CMD_LINE_TO, 1), to_zigzag(0), to_zigzag(-1)};
    send_geometry(17'd12, FT_LINE);
    // LineTo count overruns the length, so the MoveTo vertex never shows
    geo_buf = {cmd_word(CMD_MOVE_TO, 1), to_zigzag(4), to_zigzag(4),
               cmd_word(CMD_LINE_TO, 5), 32'd0, 32'd0};
    send_geometry(17'd6, FT_LINE);
    put_word(32'h0000_0000, 1'b0, 17'd0, FT_UNKNOWN);
    drain_results();
  endtask

  task automatic test_other_types;
    // oversize polygon, abandoned by the next start
    geo_buf = {cmd_word(CMD_MOVE_TO, 1)};
    send_geometry(17'h1_FFFF, FT_POLYGON);
    geo_buf = {32'hFFFF_FFFF};
    send_geometry(17'd1, FT_UNKNOWN);
    drain_results();
  endtask

  task automatic test_output_hold;
    gap_pct   = 0;
    stall_pct = 0;
    hold_seq++;
    repeat (12) begin
      build_lines(1, 3);
      send_geometry(17'(geo_buf.size()), FT_LINE);
    end
    drain_results();
    gap_pct   = 30;
    stall_pct = 20;
  endtask

  task automatic test_random_geometries;
    int          stop_at;
    int          shift_at;
    int unsigned pick;
    int unsigned m;
    logic [16:0] len;
    logic [1:0]  ft;
    stop_at  = geo_words + RANDOM_WORDS;
    shift_at = geo_words;
    build_lines(40, 2);
    send_geometry(17'(geo_buf.size()), FT_LINE);
    while (geo_words < stop_at) begin
      if (geo_words >= shift_at) begin
        shift_at = geo_words + 200;
        case ($urandom_range(0, 3))
          0:       begin stall_pct = 0;  gap_pct = 0;  end
          1:       begin stall_pct = 20; gap_pct = 30; end
          2:       begin stall_pct = 50; gap_pct = 10; end
          default: begin stall_pct = 85; gap_pct = 60; end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        build_lines($urandom_range(1, 4), $urandom_range(1, 4));
        ft = FT_LINE;
      end else if (pick < 72) begin
        build_points($urandom_range(1, 4));
        ft = FT_POINT;
      end else if (pick < 82) begin
        geo_buf = {};
        repeat ($urandom_range(1, 8)) geo_buf.push_back($urandom);
        ft = ($urandom_range(0, 1) == 0) ? FT_UNKNOWN : FT_POLYGON;
      end else begin
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 3)) put_word($urandom, 1'b0, 17'($urandom), 2'($urandom));
          1: put_word($urandom, 1'b1, 17'd0, 2'($urandom));
          2: begin
            build_lines(1, 2);
            send_geometry(17'($urandom_range(MAX_GEOMETRY_WORDS + 1, 131071)), FT_LINE);
          end
          default: begin
            geo_buf = {};
            repeat ($urandom_range(1, 6)) geo_buf.push_back($urandom);
            send_geometry(17'($urandom), 2'($urandom));
          end
        endcase
        continue;
      end
      len = 17'(geo_buf.size());
      m   = $urandom_range(0, 99);
      if (m < 10) begin
        geo_buf[$urandom_range(0, geo_buf.size() - 1)] = $urandom;
      end else if (m < 16) begin
        len = 17'($urandom_range(1, geo_buf.size()));
      end else if (m < 22) begin
        len = 17'(geo_buf.size() + $urandom_range(1, 6));
      end else if (m < 30) begin
        repeat ($urandom_range(1, 7)) geo_buf.push_back($urandom);
        len = 17'(geo_buf.size());
      end
      if ($urandom_range(0, 99) < 4) ft = 2'($urandom);
      send_geometry(len, ft);
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stray_words();
    test_point_geometries();
    test_line_geometries();
    test_other_types();
    test_output_hold();
    test_random_geometries();
    $display("Checked %0d results (%0d vertices, %0d points, %0d summaries) from %0d words",
             vertices_seen + points_seen + summaries_seen, vertices_seen, points_seen,
             summaries_seen, words_in);
    $display("Input held back for %0d cycles while the output side stalled", input_held);
    if (errors == 0) begin
      $display("vector_tile_geometry_decoder_core test passed");
    end else begin
      $display("vector_tile_geometry_decoder_core test failed");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("vector_tile_geometry_decoder_core test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/vtgd_pkg.sv
rtl/vtgd_decode.sv
rtl/vtgd_fifo.sv
rtl/vector_tile_geometry_decoder_core.sv
tb/sv/testbench.sv
